// ===== rtl/core/oli_pkg.sv =====
// Shared types and constants for the ordered list block.
package oli_pkg;

	localparam int DATA_W = 32;
	localparam int POS_W  = 6;
	localparam int OP_W   = 2;

	typedef enum logic [OP_W-1:0] {
		OP_INS_FRONT = 2'd0,
		OP_INS_BACK  = 2'd1,
		OP_DELETE    = 2'd2,
		OP_NOP       = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SHIFT,
		ST_EMIT_INIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic cin;
		logic use_rp;
	} add_ctl_t;

endpackage

// ===== rtl/core/oli_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
module oli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]           rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/oli_wrap_add.sv =====
// Shared circular pointer adder: (a + b + cin) modulo DEPTH, for sums below 2*DEPTH.
module oli_wrap_add #(
	parameter int DEPTH = 32,
	parameter int BW    = 7
) (
	input  logic [$clog2(DEPTH)-1:0] a,
	input  logic [BW-1:0]            b,
	input  logic                     cin,
	output logic [$clog2(DEPTH)-1:0] sum
);

	localparam int AW = $clog2(DEPTH);
	localparam int SW = BW + 1;

	logic [SW-1:0] raw;
	logic [SW-1:0] adj;

	always_comb begin
		raw = SW'(a) + SW'(b) + SW'(cin);
		adj = (raw >= SW'(DEPTH)) ? (raw - SW'(DEPTH)) : raw;
		sum = adj[AW-1:0];
	end

endmodule

// ===== rtl/core/ordered_list_insert_delete.sv =====
// Top level: bounded ordered list with insert front/back, delete at position, full dump.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+----------------------------------
//  in      | input     | in_valid/in_stall | op, value, position
//  out     | output    | out_valid/out_stall | entry, last, empty_res, dropped
//
// A request steps through accept, execute, emit setup, then emits one item per cycle while
// out_stall is low (one empty_res item for an empty list). A delete at a valid position
// first passes through a shift state that moves each later entry down by one place.
// The list is a circular buffer, so front inserts move no data.
// Reset clears the count and head pointer; RAM contents are left as they are.
// Out stall holds the emit sequencer; no command is taken while the block is busy.
module ordered_list_insert_delete #(
	parameter int LIST_DEPTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [oli_pkg::OP_W-1:0]          op,
	input  logic signed [oli_pkg::DATA_W-1:0] value,
	input  logic [oli_pkg::POS_W-1:0]         position,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [oli_pkg::DATA_W-1:0] entry,
	output logic                              last,
	output logic                              empty_res,
	output logic                              dropped
);

	localparam int AW = $clog2(LIST_DEPTH);
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int XW = (CW > oli_pkg::POS_W) ? CW : oli_pkg::POS_W;

	oli_pkg::state_t state_q, state_d;

	logic [AW-1:0]                 head_q, head_d;
	logic [CW-1:0]                 count_q, count_d;
	logic [AW-1:0]                 rp_q, rp_d;
	logic [AW-1:0]                 wp_q, wp_d;
	logic [CW-1:0]                 idx_q, idx_d;
	logic                          pend_q, pend_d;
	logic                          out_valid_q, out_valid_d;
	logic                          last_q, last_d;
	logic                          empty_q, empty_d;
	logic                          dropped_q, dropped_d;
	oli_pkg::op_t                  op_q;
	logic [oli_pkg::DATA_W-1:0]    value_q;
	logic [oli_pkg::POS_W-1:0]     pos_q;

	logic                          accept;
	logic                          out_free;
	logic                          full;
	logic [XW-1:0]                 pos_x;
	logic [XW-1:0]                 count_x;

	oli_pkg::add_ctl_t             actl;
	logic [XW-1:0]                 add_b;
	logic [AW-1:0]                 add_a;
	logic [AW-1:0]                 add_sum;

	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	logic [oli_pkg::DATA_W-1:0]    ram_wdata;
	logic                          ram_re;
	logic [AW-1:0]                 ram_raddr;
	logic [oli_pkg::DATA_W-1:0]    ram_rdata;

	oli_ram #(
		.WIDTH (oli_pkg::DATA_W),
		.DEPTH (LIST_DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re      (ram_re),
		.raddr   (ram_raddr),
		.rdata_q (ram_rdata)
	);

	oli_wrap_add #(
		.DEPTH (LIST_DEPTH),
		.BW    (XW)
	) u_add (
		.a   (add_a),
		.b   (add_b),
		.cin (actl.cin),
		.sum (add_sum)
	);

	assign out_free  = !out_valid_q || !out_stall;
	assign full      = (count_q == CW'(LIST_DEPTH));
	assign pos_x     = XW'(pos_q);
	assign count_x   = XW'(count_q);
	assign in_stall  = (state_q != oli_pkg::ST_IDLE) || (out_valid_q && out_stall);
	assign accept    = in_valid && !in_stall;
	assign add_a     = actl.use_rp ? rp_q : head_q;

	assign out_valid = out_valid_q;
	assign entry     = empty_q ? '0 : ram_rdata;
	assign last      = last_q;
	assign empty_res = empty_q;
	assign dropped   = dropped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= oli_pkg::ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			count_q     <= count_d;
			pend_q      <= pend_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		rp_q      <= rp_d;
		wp_q      <= wp_d;
		idx_q     <= idx_d;
		last_q    <= last_d;
		empty_q   <= empty_d;
		dropped_q <= dropped_d;
		if (accept) begin
			op_q    <= oli_pkg::op_t'(op);
			value_q <= value;
			pos_q   <= position;
		end
	end

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		count_d     = count_q;
		rp_d        = rp_q;
		wp_d        = wp_q;
		idx_d       = idx_q;
		pend_d      = pend_q;
		out_valid_d = out_valid_q && out_stall;
		last_d      = last_q;
		empty_d     = empty_q;
		dropped_d   = dropped_q;
		actl.cin    = 1'b0;
		actl.use_rp = 1'b0;
		add_b       = '0;
		ram_we      = 1'b0;
		ram_waddr   = add_sum;
		ram_wdata   = value_q;
		ram_re      = 1'b0;
		ram_raddr   = add_sum;

		case (state_q)
			oli_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = oli_pkg::ST_EXEC;
				end
			end
			oli_pkg::ST_EXEC: begin
				dropped_d = 1'b0;
				state_d   = oli_pkg::ST_EMIT_INIT;
				case (op_q)
					oli_pkg::OP_INS_FRONT: begin
						add_b = XW'(LIST_DEPTH - 1);
						if (full) begin
							dropped_d = 1'b1;
						end else begin
							ram_we  = 1'b1;
							head_d  = add_sum;
							count_d = count_q + CW'(1);
						end
					end
					oli_pkg::OP_INS_BACK: begin
						add_b = count_x;
						if (full) begin
							dropped_d = 1'b1;
						end else begin
							ram_we  = 1'b1;
							count_d = count_q + CW'(1);
						end
					end
					oli_pkg::OP_DELETE: begin
						add_b = pos_x;
						if (pos_x < count_x) begin
							rp_d    = add_sum;
							idx_d   = CW'(pos_x) + CW'(1);
							pend_d  = 1'b0;
							state_d = oli_pkg::ST_SHIFT;
						end
					end
					default: begin
					end
				endcase
			end
			oli_pkg::ST_SHIFT: begin
				actl.use_rp = 1'b1;
				actl.cin    = 1'b1;
				ram_waddr   = wp_q;
				ram_wdata   = ram_rdata;
				ram_we      = pend_q;
				if (idx_q < count_q) begin
					ram_re = 1'b1;
					wp_d   = rp_q;
					rp_d   = add_sum;
					idx_d  = idx_q + CW'(1);
					pend_d = 1'b1;
				end else begin
					pend_d = 1'b0;
					if (!pend_q) begin
						count_d = count_q - CW'(1);
						state_d = oli_pkg::ST_EMIT_INIT;
					end
				end
			end
			oli_pkg::ST_EMIT_INIT: begin
				rp_d    = head_q;
				idx_d   = '0;
				state_d = oli_pkg::ST_EMIT;
			end
			oli_pkg::ST_EMIT: begin
				actl.use_rp = 1'b1;
				actl.cin    = 1'b1;
				ram_raddr   = rp_q;
				if (out_free) begin
					out_valid_d = 1'b1;
					if (count_q == '0) begin
						empty_d = 1'b1;
						last_d  = 1'b1;
						state_d = oli_pkg::ST_IDLE;
					end else begin
						ram_re  = 1'b1;
						empty_d = 1'b0;
						rp_d    = add_sum;
						idx_d   = idx_q + CW'(1);
						last_d  = ((idx_q + CW'(1)) == count_q);
						if ((idx_q + CW'(1)) == count_q) begin
							state_d = oli_pkg::ST_IDLE;
						end
					end
				end
			end
			default: begin
				state_d = oli_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== test/ordered_list_insert_delete_test.sv =====
// Self-checking testbench for ordered_list_insert_delete: directed table, then random traffic.
module ordered_list_insert_delete_test;

	localparam int DEPTH = 32;
	localparam int N_RANDOM = 313;
	localparam int HOLD_CYCLES = 300;
	localparam logic signed [oli_pkg::DATA_W-1:0] W_MAX = 32'sh7fff_ffff;
	localparam logic signed [oli_pkg::DATA_W-1:0] W_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic signed [oli_pkg::DATA_W-1:0] entry;
		logic                              last;
		logic                              empty_res;
		logic                              dropped;
	} list_item_t;

	typedef struct packed {
		oli_pkg::op_t                      cmd;
		logic signed [oli_pkg::DATA_W-1:0] val;
		logic [oli_pkg::POS_W-1:0]         pos;
		logic                              typed;
		list_item_t                        want;
	} stim_row_t;

	typedef enum {MIX_GROW, MIX_FULL, MIX_SHRINK, MIX_CHURN} mix_t;

	localparam list_item_t EMPTY_LIST = '{entry: '0, last: 1'b1, empty_res: 1'b1, dropped: 1'b0};
	localparam list_item_t NO_ITEM = '0;
	localparam oli_pkg::op_t GROW_OPS[10] = '{oli_pkg::OP_INS_FRONT, oli_pkg::OP_INS_FRONT,
		oli_pkg::OP_INS_FRONT, oli_pkg::OP_INS_FRONT, oli_pkg::OP_INS_BACK, oli_pkg::OP_INS_BACK,
		oli_pkg::OP_INS_BACK, oli_pkg::OP_INS_BACK, oli_pkg::OP_DELETE, oli_pkg::OP_NOP};
	localparam oli_pkg::op_t FULL_OPS[10] = '{oli_pkg::OP_INS_FRONT, oli_pkg::OP_INS_FRONT,
		oli_pkg::OP_INS_FRONT, oli_pkg::OP_INS_FRONT, oli_pkg::OP_INS_BACK, oli_pkg::OP_INS_BACK,
		oli_pkg::OP_INS_BACK, oli_pkg::OP_INS_BACK, oli_pkg::OP_NOP, oli_pkg::OP_NOP};
	localparam oli_pkg::op_t SHRINK_OPS[10] = '{oli_pkg::OP_DELETE, oli_pkg::OP_DELETE,
		oli_pkg::OP_DELETE, oli_pkg::OP_DELETE, oli_pkg::OP_DELETE, oli_pkg::OP_DELETE,
		oli_pkg::OP_DELETE, oli_pkg::OP_DELETE, oli_pkg::OP_INS_BACK, oli_pkg::OP_NOP};

	logic                              clk;
	logic                              arst_n;
	logic                              in_valid;
	logic                              in_stall;
	logic [oli_pkg::OP_W-1:0]          op;
	logic signed [oli_pkg::DATA_W-1:0] value;
	logic [oli_pkg::POS_W-1:0]         position;
	logic                              out_valid;
	logic                              out_stall;
	logic signed [oli_pkg::DATA_W-1:0] entry;
	logic                              last;
	logic                              empty_res;
	logic                              dropped;

	logic signed [oli_pkg::DATA_W-1:0] list_mem [DEPTH];
	int                       list_len;
	list_item_t               want_q[$];
	int                       errors;
	int                       n_requests;
	int                       n_checked;
	int                       n_dropped;
	int                       n_ignored;
	int                       peak_len;
	int                       burst_left;
	bit                       hold_off_armed;
	bit                       hold_off_used;

	ordered_list_insert_delete #(
		.LIST_DEPTH(DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.value(value),
		.position(position),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.entry(entry),
		.last(last),
		.empty_res(empty_res),
		.dropped(dropped)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Update the list copy and, if queue_it is set, queue the dump the block should emit.
	task automatic apply_command(input oli_pkg::op_t cmd,
			input logic signed [oli_pkg::DATA_W-1:0] val,
			input logic [oli_pkg::POS_W-1:0] pos, input bit queue_it);
		bit         drop;
		list_item_t item;
		drop = 1'b0;
		case (cmd)
		oli_pkg::OP_INS_FRONT, oli_pkg::OP_INS_BACK: begin
			if (list_len >= DEPTH) begin
				drop = 1'b1;
				n_dropped++;
			end else if (cmd == oli_pkg::OP_INS_FRONT) begin
				for (int i = list_len; i > 0; i--)
					list_mem[i] = list_mem[i - 1];
				list_mem[0] = val;
				list_len++;
			end else begin
				list_mem[list_len] = val;
				list_len++;
			end
		end
		oli_pkg::OP_DELETE: begin
			if (pos < list_len) begin
				for (int i = pos; i + 1 < list_len; i++)
					list_mem[i] = list_mem[i + 1];
				list_len--;
			end else begin
				n_ignored++;
			end
		end
		default: ;
		endcase
		if (list_len > peak_len)
			peak_len = list_len;
		if (queue_it) begin
			if (list_len == 0) begin
				item = EMPTY_LIST;
				item.dropped = drop;
				want_q.push_back(item);
			end
			for (int i = 0; i < list_len; i++) begin
				item.entry = list_mem[i];
				item.last = (i == list_len - 1);
				item.empty_res = 1'b0;
				item.dropped = drop;
				want_q.push_back(item);
			end
		end
	endtask

	// Offer one request, wait for it to be taken, then pace the sender.
	task automatic issue(input oli_pkg::op_t cmd, input logic signed [oli_pkg::DATA_W-1:0] val,
			input logic [oli_pkg::POS_W-1:0] pos, input bit typed, input list_item_t want);
		in_valid <= 1'b1;
		op <= cmd;
		value <= val;
		position <= pos;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		n_requests++;
		if (typed)
			want_q.push_back(want);
		apply_command(cmd, val, pos, !typed);
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12))
				@(posedge clk);
			if ($urandom_range(0, 3) == 0)
				burst_left = $urandom_range(20, 40);
			else
				burst_left = $urandom_range(1, 6);
		end
	endtask

	function automatic void check_field(input string name,
			input logic [oli_pkg::DATA_W-1:0] want, input logic [oli_pkg::DATA_W-1:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : result_check
		list_item_t head;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			n_checked++;
			if (want_q.size() == 0) begin
				errors++;
				$display("%0t: list item expected none actual entry %0h last %0b", $time,
					entry, last);
			end else begin
				head = want_q.pop_front();
				check_field("entry", head.entry, entry);
				check_field("last", oli_pkg::DATA_W'(head.last), oli_pkg::DATA_W'(last));
				check_field("empty_res", oli_pkg::DATA_W'(head.empty_res),
					oli_pkg::DATA_W'(empty_res));
				check_field("dropped", oli_pkg::DATA_W'(head.dropped),
					oli_pkg::DATA_W'(dropped));
			end
		end
	end

	// Receiver: quiet stretches, short and long stalls, and one long hold-off.
	initial begin : stall_pattern
		bit st;
		int run;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_off_armed) begin
				hold_off_armed = 1'b0;
				st = 1'b1;
				run = HOLD_CYCLES;
			end else begin
				case ($urandom_range(0, 3))
				0: begin
					st = 1'b0;
					run = $urandom_range(20, 80);
				end
				1: begin
					st = 1'b1;
					run = $urandom_range(1, 8);
				end
				default: begin
					st = 1'($urandom_range(0, 1));
					run = $urandom_range(1, 3);
				end
				endcase
			end
			out_stall <= st;
			repeat (run)
				@(posedge clk);
		end
	end

	initial begin : request_driver
		stim_row_t                         directed [17];
		mix_t                              mix;
		int                                r;
		int                                mix_left;
		int                                guard;
		oli_pkg::op_t                      cmd;
		logic signed [oli_pkg::DATA_W-1:0] val;
		logic [oli_pkg::POS_W-1:0]         pos;

		arst_n = 1'b0;
		in_valid = 1'b0;
		op = oli_pkg::OP_NOP;
		value = '0;
		position = '0;
		list_len = 0;
		errors = 0;
		n_requests = 0;
		n_checked = 0;
		n_dropped = 0;
		n_ignored = 0;
		peak_len = 0;
		burst_left = 3;
		hold_off_armed = 1'b0;
		hold_off_used = 1'b0;

		directed = '{
			'{oli_pkg::OP_NOP,       32'sh5a5a_5a5a, 6'd63, 1'b1, EMPTY_LIST},
			'{oli_pkg::OP_DELETE,    32'sd0,         6'd0,  1'b1, EMPTY_LIST},
			'{oli_pkg::OP_DELETE,    -32'sd1,        6'd63, 1'b1, EMPTY_LIST},
			'{oli_pkg::OP_INS_BACK,  W_MAX,          6'd63, 1'b1, '{W_MAX, 1'b1, 1'b0, 1'b0}},
			'{oli_pkg::OP_DELETE,    32'sd7,         6'd1,  1'b1, '{W_MAX, 1'b1, 1'b0, 1'b0}},
			'{oli_pkg::OP_DELETE,    W_MIN,          6'd0,  1'b1, EMPTY_LIST},
			'{oli_pkg::OP_INS_FRONT, W_MIN,          6'd42, 1'b1, '{W_MIN, 1'b1, 1'b0, 1'b0}},
			'{oli_pkg::OP_INS_FRONT, -32'sd1,        6'd0,  1'b0, NO_ITEM},
			'{oli_pkg::OP_INS_BACK,  32'sd0,         6'd21, 1'b0, NO_ITEM},
			'{oli_pkg::OP_INS_BACK,  32'sd1,         6'd63, 1'b0, NO_ITEM},
			'{oli_pkg::OP_NOP,       W_MIN,          6'd21, 1'b0, NO_ITEM},
			'{oli_pkg::OP_DELETE,    W_MAX,          6'd1,  1'b0, NO_ITEM},
			'{oli_pkg::OP_DELETE,    32'sd0,         6'd2,  1'b0, NO_ITEM},
			'{oli_pkg::OP_DELETE,    32'sd0,         6'd3,  1'b0, NO_ITEM},
			'{oli_pkg::OP_DELETE,    32'sd0,         6'd0,  1'b0, NO_ITEM},
			'{oli_pkg::OP_INS_FRONT, 32'sh8000_0001, 6'd63, 1'b0, NO_ITEM},
			'{oli_pkg::OP_DELETE,    -32'sd1,        6'd42, 1'b0, NO_ITEM}
		};

		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			issue(directed[i].cmd, directed[i].val, directed[i].pos, directed[i].typed,
				directed[i].want);

		// Random part: fill to full, push on it, drain to empty, churn, repeat.
		mix = MIX_GROW;
		mix_left = 0;
		for (int k = 0; k < N_RANDOM; k++) begin
			r = $urandom_range(0, 9);
			case (mix)
			MIX_GROW:   cmd = GROW_OPS[r];
			MIX_FULL:   cmd = FULL_OPS[r];
			MIX_SHRINK: cmd = SHRINK_OPS[r];
			default:    cmd = oli_pkg::op_t'($urandom_range(0, 3));
			endcase
			case ($urandom_range(0, 7))
			0: val = W_MAX;
			1: val = W_MIN;
			2: val = '0;
			3: val = '1;
			default: val = $urandom;
			endcase
			pos = oli_pkg::POS_W'($urandom);
			if (cmd == oli_pkg::OP_DELETE && list_len > 0 && $urandom_range(0, 5) != 0) begin
				case ($urandom_range(0, 3))
				0: pos = '0;
				1: pos = oli_pkg::POS_W'(list_len - 1);
				default: pos = oli_pkg::POS_W'($urandom_range(0, list_len - 1));
				endcase
			end
			if (!hold_off_used && list_len >= 20) begin
				hold_off_used = 1'b1;
				hold_off_armed = 1'b1;
			end
			issue(cmd, val, pos, 1'b0, NO_ITEM);
			case (mix)
			MIX_GROW: begin
				if (list_len == DEPTH) begin
					mix = MIX_FULL;
					mix_left = $urandom_range(3, 8);
				end
			end
			MIX_FULL: begin
				mix_left--;
				if (mix_left <= 0)
					mix = MIX_SHRINK;
			end
			MIX_SHRINK: begin
				if (list_len == 0) begin
					mix = MIX_CHURN;
					mix_left = $urandom_range(5, 15);
				end
			end
			default: begin
				mix_left--;
				if (mix_left <= 0)
					mix = MIX_GROW;
			end
			endcase
		end

		in_valid <= 1'b0;
		guard = 0;
		while (want_q.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (80)
			@(posedge clk);
		if (want_q.size() != 0) begin
			errors++;
			$display("%0t: %0d list items expected actual none", $time, want_q.size());
		end

		$display("%0d requests: %0d inserts refused on a full list, %0d deletes ignored",
			n_requests, n_dropped, n_ignored);
		$display("%0d list items checked, longest list %0d of %0d, %0d mismatches",
			n_checked, peak_len, DEPTH, errors);
		if (errors == 0)
			$display("ordered_list_insert_delete_test: PASS");
		else
			$display("ordered_list_insert_delete_test: FAIL");
		$finish;
	end

	initial begin : watchdog
		#5000000;
		$display("%0t: timeout, %0d list items still expected", $time, want_q.size());
		$display("ordered_list_insert_delete_test: FAIL");
		$finish;
	end

endmodule
